>>> hdl/apsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsf_pkg
// Types, constants and the volume scaling function of the audio PWM sample
// FIFO.
// ----------------------------------------------------------------------------
package apsf_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int LEVEL_W   = 12;
   localparam int VOL_W     = 4;
   localparam int MULT_W    = 12;
   localparam int PRODUCT_W = SAMPLE_W + MULT_W;

   localparam logic [VOL_W-1:0]   VOL_RESET = 4'd6;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL = 12'd2176;

   // Flipping the sign bit is the same as adding 32768.
   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      logic accepted;
      logic underrun;
      logic popped;
   } ring_res_type;

   // Volume multiplier; codes above nine saturate to the loudest setting.
   function automatic logic [MULT_W-1:0] vol_mult(input logic [VOL_W-1:0] vol);
      logic [MULT_W-1:0] mult;
      case (vol)
         4'd0:    mult = 12'd96;
         4'd1:    mult = 12'd136;
         4'd2:    mult = 12'd192;
         4'd3:    mult = 12'd272;
         4'd4:    mult = 12'd384;
         4'd5:    mult = 12'd544;
         4'd6:    mult = 12'd769;
         4'd7:    mult = 12'd1088;
         4'd8:    mult = 12'd1539;
         default: mult = 12'd2177;
      endcase
      return mult;
   endfunction

   // Offset to unsigned, scale, keep the top bits of the product.
   function automatic logic [LEVEL_W-1:0] scale_sample(
      input logic signed [SAMPLE_W-1:0] sample,
      input logic [VOL_W-1:0]           vol
   );
      logic [SAMPLE_W-1:0]  offs;
      logic [PRODUCT_W-1:0] prod;
      offs = SAMPLE_W'(sample) ^ SIGN_FLIP;
      prod = PRODUCT_W'(offs) * PRODUCT_W'(vol_mult(vol));
      return prod[PRODUCT_W-1 -: LEVEL_W];
   endfunction

endpackage

>>> hdl/apsf_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsf_req_if
// Input channel: push a sample or tick one PWM period.
// ----------------------------------------------------------------------------
interface apsf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  kind;
   logic signed [apsf_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output kind, output sample, input ready);
   modport sink   (input valid, input kind, input sample, output ready);
endinterface

>>> hdl/apsf_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsf_rsp_if
// Result channel: status flags and the current stereo PWM levels.
// ----------------------------------------------------------------------------
interface apsf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            accepted;
   logic                            underrun;
   logic [apsf_pkg::LEVEL_W-1:0]    left_level;
   logic [apsf_pkg::LEVEL_W-1:0]    right_level;

   modport source (output valid, output accepted, output underrun,
                   output left_level, output right_level, input ready);
   modport sink   (input valid, input accepted, input underrun,
                   input left_level, input right_level, output ready);
endinterface

>>> hdl/apsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsf_ram
// Generic RAM, one write port and two registered read ports with enable.
// ----------------------------------------------------------------------------
module apsf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a_ff,
   output logic [WIDTH-1:0]         rd_data_b_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

endmodule

>>> hdl/apsf_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsf_ring
// Ring pointers, full/underrun decisions and the level store.
// ----------------------------------------------------------------------------
module apsf_ring #(
   parameter int RING_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            kind,
   input  logic [apsf_pkg::LEVEL_W-1:0]    level,
   output apsf_pkg::ring_res_type          res_ff,
   output logic [apsf_pkg::LEVEL_W-1:0]    rd_left,
   output logic [apsf_pkg::LEVEL_W-1:0]    rd_right
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      return (p == LAST_POS) ? '0 : p + 1'b1;
   endfunction

   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]         wr_nxt, rd_nxt, rd_nxt2;
   logic                     full, can_pop, is_push, is_tick, wr_en, pop;
   apsf_pkg::ring_res_type   res_in;

   always_comb begin
      wr_nxt  = next_pos(wr_ptr_ff);
      rd_nxt  = next_pos(rd_ptr_ff);
      rd_nxt2 = next_pos(rd_nxt);
      // one slot always stays empty
      full    = (wr_nxt == rd_ptr_ff);
      can_pop = (rd_ptr_ff != wr_ptr_ff) && (rd_nxt != wr_ptr_ff);
      is_push = step && (kind == apsf_pkg::KIND_PUSH);
      is_tick = step && (kind == apsf_pkg::KIND_TICK);
      wr_en   = is_push && !full;
      pop     = is_tick && can_pop;

      wr_ptr_in = wr_en ? wr_nxt  : wr_ptr_ff;
      rd_ptr_in = pop   ? rd_nxt2 : rd_ptr_ff;

      res_in          = res_ff;
      if (step) begin
         res_in.accepted = is_tick || !full;
         res_in.underrun = is_tick && !can_pop;
         res_in.popped   = pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         res_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         res_ff    <= res_in;
      end
   end

   apsf_ram #(
      .WIDTH (apsf_pkg::LEVEL_W),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_ptr_ff),
      .wr_data      (level),
      .rd_en        (pop),
      .rd_addr_a    (rd_ptr_ff),
      .rd_addr_b    (rd_nxt),
      .rd_data_a_ff (rd_left),
      .rd_data_b_ff (rd_right)
   );

endmodule

>>> hdl/audio_pwm_sample_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_pwm_sample_fifo
// Sample FIFO and level holder in front of a stereo PWM stage.
// ----------------------------------------------------------------------------
// req_if carries one item per transfer: a push (kind 0) scales the signed
// sample by the volume setting and queues the level; a tick (kind 1) pops a
// left/right pair when at least two levels are queued, else repeats the held
// pair and raises underrun. A push into a full ring is dropped with
// accepted low. Every item gives exactly one transfer on rsp_if carrying the
// flags and the current held levels.
// csr_wr_en/csr_wr_data write the 4-bit volume setting (reset value 6);
// write it only while the block is idle.
// The result passes through the input register, the ring access with
// registered read and the result register. Throughput is one item per
// cycle while rsp_if does not stall: the ring RAM has two read ports, so a
// tick reads both entries of its pair in one access.
// Reset clears the ring pointers, the held levels and all valid flags; the
// ring contents need no clearing. When rsp_if stalls, the result and the two
// stages behind it hold and fill up before req_if.ready drops.
// ----------------------------------------------------------------------------
module audio_pwm_sample_fifo #(
   parameter int RING_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   apsf_req_if.sink                       req_if,
   apsf_rsp_if.source                     rsp_if,
   input  logic                           csr_wr_en,
   input  logic [apsf_pkg::VOL_W-1:0]     csr_wr_data
);

   logic [apsf_pkg::VOL_W-1:0]            vol_ff, vol_in;

   logic                                  s1_vld_ff, s1_vld_in;
   logic                                  s1_kind_ff;
   logic signed [apsf_pkg::SAMPLE_W-1:0]  s1_sample_ff;
   logic                                  s2_vld_ff, s2_vld_in;
   logic                                  rsp_vld_ff, rsp_vld_in;
   logic                                  rsp_acc_ff, rsp_und_ff;
   logic [apsf_pkg::LEVEL_W-1:0]          held_left_ff, held_left_in;
   logic [apsf_pkg::LEVEL_W-1:0]          held_right_ff, held_right_in;

   logic                                  adv_out, adv2, adv1, accept, step, out_load;
   logic [apsf_pkg::LEVEL_W-1:0]          level;
   logic [apsf_pkg::LEVEL_W-1:0]          rd_left, rd_right;
   apsf_pkg::ring_res_type                ring_res;

   // Stage advance: each stage moves when the one after it has room.
   always_comb begin
      adv_out  = !rsp_vld_ff || rsp_if.ready;
      adv2     = !s2_vld_ff || adv_out;
      adv1     = !s1_vld_ff || adv2;
      accept   = req_if.valid && adv1;
      step     = s1_vld_ff && adv2;
      out_load = s2_vld_ff && adv_out;

      vol_in     = csr_wr_en ? csr_wr_data : vol_ff;
      s1_vld_in  = accept ? 1'b1 : (adv2 ? 1'b0 : s1_vld_ff);
      s2_vld_in  = step ? 1'b1 : (adv_out ? 1'b0 : s2_vld_ff);
      rsp_vld_in = out_load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_vld_ff);

      level = apsf_pkg::scale_sample(s1_sample_ff, vol_ff);

      // take the popped pair, otherwise hold
      held_left_in  = (out_load && ring_res.popped) ? rd_left  : held_left_ff;
      held_right_in = (out_load && ring_res.popped) ? rd_right : held_right_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff        <= apsf_pkg::VOL_RESET;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
      end else begin
         vol_ff        <= vol_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= req_if.kind;
         s1_sample_ff <= req_if.sample;
      end
      if (out_load) begin
         rsp_acc_ff <= ring_res.accepted;
         rsp_und_ff <= ring_res.underrun;
      end
   end

   apsf_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .kind     (s1_kind_ff),
      .level    (level),
      .res_ff   (ring_res),
      .rd_left  (rd_left),
      .rd_right (rd_right)
   );

   assign req_if.ready       = adv1;
   assign rsp_if.valid       = rsp_vld_ff;
   assign rsp_if.accepted    = rsp_acc_ff;
   assign rsp_if.underrun    = rsp_und_ff;
   assign rsp_if.left_level  = held_left_ff;
   assign rsp_if.right_level = held_right_ff;

   // an accepted item always lands in the input stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> s1_vld_ff)
      else $error("accepted item not captured");

   // underrun only on a tick, which is always accepted
   a_underrun_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.underrun) |-> rsp_if.accepted)
      else $error("underrun without accepted");

   // levels stay within the scaled range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.left_level <= apsf_pkg::MAX_LEVEL &&
                        rsp_if.right_level <= apsf_pkg::MAX_LEVEL))
      else $error("PWM level out of range");

endmodule

>>> tb/tb_audio_pwm_sample_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_pwm_sample_fifo
// Self-checking bench for the audio PWM sample FIFO.
// ----------------------------------------------------------------------------
// A level predictor tracks the volume setting, the queued levels and the held
// stereo pair, and works out the response to each accepted push or tick. The
// responses are checked in order, field by field. Stimulus starts with a
// short directed run over sample extremes, underruns and volume saturation,
// then random phases fill the ring past full, drain it into underrun and mix
// both, with random gaps and stalls on both channels unless back-to-back.
// ----------------------------------------------------------------------------
module tb_audio_pwm_sample_fifo;

   localparam int          RING_DEPTH  = 256;
   localparam int          NUM_PHASES  = 8;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                         accepted;
      logic                         underrun;
      logic [apsf_pkg::LEVEL_W-1:0] left_level;
      logic [apsf_pkg::LEVEL_W-1:0] right_level;
   } level_rsp_type;

   class level_scoreboard;
      level_rsp_type                expected_q[$];
      logic [apsf_pkg::LEVEL_W-1:0] ring_q[$];
      logic [apsf_pkg::LEVEL_W-1:0] held_left;
      logic [apsf_pkg::LEVEL_W-1:0] held_right;
      logic [apsf_pkg::VOL_W-1:0]   volume;
      int unsigned                  vol_mult[10];
      int unsigned                  errors;

      function new();
         vol_mult   = '{96, 136, 192, 272, 384, 544, 769, 1088, 1539, 2177};
         volume     = apsf_pkg::VOL_RESET;
         held_left  = '0;
         held_right = '0;
         errors     = 0;
      endfunction

      function void set_volume(logic [apsf_pkg::VOL_W-1:0] v);
         volume = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [apsf_pkg::LEVEL_W-1:0] scaled_level(
         logic [apsf_pkg::SAMPLE_W-1:0] sample
      );
         logic [apsf_pkg::SAMPLE_W-1:0]  offs;
         logic [apsf_pkg::PRODUCT_W-1:0] prod;
         int unsigned                    idx;
         // codes above nine act as the loudest setting
         idx  = (volume > 9) ? 9 : int'(volume);
         offs = sample ^ apsf_pkg::SIGN_FLIP;
         prod = apsf_pkg::PRODUCT_W'(offs) * apsf_pkg::PRODUCT_W'(vol_mult[idx]);
         return prod[apsf_pkg::PRODUCT_W-1 -: apsf_pkg::LEVEL_W];
      endfunction

      function void note_input(apsf_pkg::kind_type kind,
                               logic [apsf_pkg::SAMPLE_W-1:0] sample);
         level_rsp_type r;
         r.accepted = 1'b1;
         r.underrun = 1'b0;
         if (kind == apsf_pkg::KIND_PUSH) begin
            // one slot always stays empty
            if (ring_q.size() < RING_DEPTH - 1)
               ring_q.push_back(scaled_level(sample));
            else
               r.accepted = 1'b0;
         end else if (ring_q.size() >= 2) begin
            held_left  = ring_q.pop_front();
            held_right = ring_q.pop_front();
         end else begin
            r.underrun = 1'b1;
         end
         r.left_level  = held_left;
         r.right_level = held_right;
         expected_q.push_back(r);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(level_rsp_type got);
         level_rsp_type want;
         if (expected_q.size() == 0) begin
            report("response with nothing outstanding");
            return;
         end
         want = expected_q.pop_front();
         if (got.accepted !== want.accepted)
            report($sformatf("accepted got %0b want %0b", got.accepted, want.accepted));
         if (got.underrun !== want.underrun)
            report($sformatf("underrun got %0b want %0b", got.underrun, want.underrun));
         if (got.left_level !== want.left_level)
            report($sformatf("left_level got %0d want %0d",
                             got.left_level, want.left_level));
         if (got.right_level !== want.right_level)
            report($sformatf("right_level got %0d want %0d",
                             got.right_level, want.right_level));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [apsf_pkg::VOL_W-1:0] csr_wr_data;

   apsf_req_if req_if();
   apsf_rsp_if rsp_if();

   level_scoreboard sb = new();

   bit          req_gap_en   = 1'b1;
   bit          rsp_stall_en = 1'b1;
   int unsigned cycle_count  = 0;

   audio_pwm_sample_fifo #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if.sink),
      .rsp_if      (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: random stall before each transfer when enabled, then check it.
   initial begin
      int unsigned   stall;
      level_rsp_type got;
      forever begin
         stall = rsp_stall_en ? $urandom_range(0, 10) : 0;
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
         got.accepted    = rsp_if.accepted;
         got.underrun    = rsp_if.underrun;
         got.left_level  = rsp_if.left_level;
         got.right_level = rsp_if.right_level;
         sb.check_result(got);
      end
   end

   task send_item(input apsf_pkg::kind_type kind,
                  input logic [apsf_pkg::SAMPLE_W-1:0] sample);
      int unsigned gap;
      gap = req_gap_en ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.kind   <= kind;
      req_if.sample <= sample;
      do @(posedge clock);
      while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
      sb.note_input(kind, sample);
   endtask

   // Hold the sender until every outstanding response is back.
   task wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock);
      while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task set_volume(input logic [apsf_pkg::VOL_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_volume(v);
   endtask

   initial begin
      logic [apsf_pkg::VOL_W-1:0]    vol_plan [NUM_PHASES];
      logic [apsf_pkg::SAMPLE_W-1:0] sample;
      int unsigned                   style;
      int unsigned                   push_pct;
      int unsigned                   n_items;
      apsf_pkg::kind_type            kind;

      vol_plan = '{4'd0, 4'd9, 4'd15, 4'd3, 4'd10, 4'd7, 4'd1, 4'd12};

      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.kind   <= apsf_pkg::KIND_PUSH;
      req_if.sample <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Underrun on an empty ring, then with a single level queued.
      send_item(apsf_pkg::KIND_TICK, 16'h1234);
      send_item(apsf_pkg::KIND_PUSH, 16'h8000);
      send_item(apsf_pkg::KIND_TICK, 16'hFFFF);
      send_item(apsf_pkg::KIND_PUSH, 16'h7FFF);
      send_item(apsf_pkg::KIND_TICK, 16'h0000);
      send_item(apsf_pkg::KIND_PUSH, 16'h0000);
      send_item(apsf_pkg::KIND_PUSH, 16'hFFFF);
      send_item(apsf_pkg::KIND_PUSH, 16'h0001);
      send_item(apsf_pkg::KIND_TICK, 16'h5A5A);
      send_item(apsf_pkg::KIND_TICK, 16'hA5A5);
      wait_idle();

      // Quietest and loudest settings, then out-of-range codes that saturate.
      set_volume(4'd0);
      send_item(apsf_pkg::KIND_PUSH, 16'h8000);
      send_item(apsf_pkg::KIND_PUSH, 16'h7FFF);
      send_item(apsf_pkg::KIND_TICK, 16'h0000);
      wait_idle();
      set_volume(4'd9);
      send_item(apsf_pkg::KIND_PUSH, 16'h7FFF);
      send_item(apsf_pkg::KIND_PUSH, 16'h8000);
      send_item(apsf_pkg::KIND_TICK, 16'h0000);
      wait_idle();
      set_volume(4'd15);
      send_item(apsf_pkg::KIND_PUSH, 16'h7FFF);
      send_item(apsf_pkg::KIND_PUSH, 16'hFFFF);
      send_item(apsf_pkg::KIND_TICK, 16'h0000);
      wait_idle();
      set_volume(4'd10);
      send_item(apsf_pkg::KIND_PUSH, 16'h7FFF);
      send_item(apsf_pkg::KIND_PUSH, 16'h0000);
      send_item(apsf_pkg::KIND_TICK, 16'h0000);
      wait_idle();

      // Phases: mixed, fill past full, drain into underrun, back-to-back mixed.
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_volume(vol_plan[p]);
         style = p % 4;
         case (style)
            0:       begin push_pct = 50; n_items = 150; end
            1:       begin push_pct = 85; n_items = 400; end
            2:       begin push_pct = 20; n_items = 300; end
            default: begin push_pct = 50; n_items = 150; end
         endcase
         req_gap_en   = (style != 3);
         rsp_stall_en = (style != 3);
         for (int i = 0; i < n_items; i++) begin
            kind = ($urandom_range(0, 99) < push_pct) ? apsf_pkg::KIND_PUSH
                                                      : apsf_pkg::KIND_TICK;
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0:       sample = 16'h8000;
                  1:       sample = 16'h7FFF;
                  2:       sample = 16'h0000;
                  default: sample = 16'hFFFF;
               endcase
            end else begin
               sample = apsf_pkg::SAMPLE_W'($urandom);
            end
            send_item(kind, sample);
            if (style == 0 && $urandom_range(0, 99) == 0)
               wait_idle();
         end
         wait_idle();
      end

      req_gap_en   = 1'b1;
      rsp_stall_en = 1'b1;
      wait_idle();
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
hdl/apsf_pkg.sv
hdl/apsf_req_if.sv
hdl/apsf_rsp_if.sv
hdl/apsf_ram.sv
hdl/apsf_ring.sv
hdl/audio_pwm_sample_fifo.sv
tb/tb_audio_pwm_sample_fifo.sv
